// ----- src/vzd_pkg.sv -----
package vzd_pkg;

  // Field kinds as they arrive on field_kind_i.
  typedef enum logic [2:0] {
    KIND_U16  = 3'd0,
    KIND_U32  = 3'd1,
    KIND_U64  = 3'd2,
    KIND_S16  = 3'd3,
    KIND_S32  = 3'd4,
    KIND_S64  = 3'd5,
    KIND_RAW1 = 3'd6,
    KIND_RAW8 = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_LONG = 2'd1,
    STATUS_TRUNC    = 2'd2
  } status_e;

  // What the back end does with one classified word.
  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_DONE  = 2'd1,
    OP_FAIL  = 2'd2
  } op_e;

  localparam int unsigned ValueW = 64;
  localparam int unsigned ShiftW = 6;
  localparam int unsigned LenW   = 4;
  localparam logic [7:0]  GroupMask = 8'h7F;

  // Depth of the queues between the stages.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    op_e              op;
    kind_e            kind;
    logic [7:0]       group;
    logic [ShiftW-1:0] shift;
    logic [LenW-1:0]  len;
    status_e          status;
  } mid_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    status_e           status;
    logic [LenW-1:0]   len;
  } result_t;

  function automatic logic [LenW-1:0] max_bytes(input kind_e kind);
    logic [LenW-1:0] n;
    unique case (kind) inside
      KIND_U16, KIND_S16: n = LenW'(3);
      KIND_U32, KIND_S32: n = LenW'(5);
      default:            n = LenW'(10);
    endcase
    return n;
  endfunction

  function automatic logic [ValueW-1:0] width_mask(input kind_e kind);
    logic [ValueW-1:0] m;
    unique case (kind) inside
      KIND_U16, KIND_S16: m = {{(ValueW-16){1'b0}}, {16{1'b1}}};
      KIND_U32, KIND_S32: m = {{(ValueW-32){1'b0}}, {32{1'b1}}};
      default:            m = {ValueW{1'b1}};
    endcase
    return m;
  endfunction

  function automatic logic is_signed(input kind_e kind);
    return (kind == KIND_S16) || (kind == KIND_S32) || (kind == KIND_S64);
  endfunction

endpackage

// ----- src/vzd_fifo.sv -----
module vzd_fifo
  import vzd_pkg::*;
#(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  logic [Width-1:0] entries_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entries_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QPtrW'(QDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPtrW'(QDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wptr_q] <= data_i;
    end
  end

endmodule

// ----- src/vzd_front.sv -----
module vzd_front
  import vzd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       full_i,
  input  logic [7:0] data_byte_i,
  input  logic [2:0] field_kind_i,
  input  logic       byte_valid_i,
  output logic       mid_push_o,
  output mid_t       mid_data_o
);

  logic            in_field_q, in_field_d;
  kind_e           kind_q, kind_d;
  logic [LenW-1:0] cnt_q, cnt_d;

  kind_e           kind_cur;
  logic [LenW-1:0] idx;
  logic [LenW-1:0] idx_next;
  mid_t            entry;

  always_comb begin
    kind_cur = in_field_q ? kind_q : kind_e'(field_kind_i);
    idx      = in_field_q ? cnt_q : '0;
    idx_next = idx + 1'b1;

    entry        = '0;
    entry.kind   = kind_cur;
    entry.op     = OP_ACCUM;
    entry.status = STATUS_OK;

    if (!byte_valid_i) begin
      entry.op     = OP_FAIL;
      entry.status = STATUS_TRUNC;
    end else begin
      unique case (kind_cur)
        KIND_RAW1: begin
          entry.op    = OP_DONE;
          entry.group = data_byte_i;
          entry.len   = LenW'(1);
        end
        KIND_RAW8: begin
          entry.group = data_byte_i;
          entry.shift = {idx[2:0], 3'b000};
          entry.len   = LenW'(8);
          entry.op    = (idx[2:0] == 3'd7) ? OP_DONE : OP_ACCUM;
        end
        default: begin
          entry.group = data_byte_i & GroupMask;
          entry.shift = ShiftW'({2'b00, idx} * 6'd7);
          entry.len   = idx_next;
          if (data_byte_i[7]) begin
            // A continuation on the last allowed byte ends the field as too long.
            if (idx_next >= max_bytes(kind_cur)) begin
              entry.op     = OP_FAIL;
              entry.status = STATUS_TOO_LONG;
              entry.len    = '0;
            end else begin
              entry.op = OP_ACCUM;
            end
          end else begin
            entry.op = OP_DONE;
          end
        end
      endcase
    end
  end

  // An exhausted buffer between fields produces nothing for the back end.
  assign mid_push_o = push_i && !full_i && (byte_valid_i || in_field_q);
  assign mid_data_o = entry;

  always_comb begin
    in_field_d = in_field_q;
    kind_d     = kind_q;
    cnt_d      = cnt_q;
    if (mid_push_o) begin
      if (entry.op == OP_ACCUM) begin
        in_field_d = 1'b1;
        kind_d     = kind_cur;
        cnt_d      = idx_next;
      end else begin
        in_field_d = 1'b0;
        cnt_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_field_q <= 1'b0;
      kind_q     <= KIND_U16;
      cnt_q      <= '0;
    end else begin
      in_field_q <= in_field_d;
      kind_q     <= kind_d;
      cnt_q      <= cnt_d;
    end
  end

endmodule

// ----- src/vzd_back.sv -----
module vzd_back
  import vzd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    mid_empty_i,
  input  mid_t    mid_data_i,
  output logic    mid_pop_o,
  input  logic    res_full_i,
  output logic    res_push_o,
  output result_t res_data_o
);

  logic [ValueW-1:0] acc_q, acc_d;
  logic [ValueW-1:0] acc_n;
  logic [ValueW-1:0] masked;
  logic              emits;

  // Every field ends in a done or fail word, which clears the accumulator,
  // so it is zero again when the next field begins.
  assign acc_n  = acc_q | ({{(ValueW-8){1'b0}}, mid_data_i.group} << mid_data_i.shift);
  assign masked = acc_n & width_mask(mid_data_i.kind);
  assign emits  = (mid_data_i.op != OP_ACCUM);

  assign mid_pop_o  = !mid_empty_i && (!emits || !res_full_i);
  assign res_push_o = !mid_empty_i && emits;

  always_comb begin
    res_data_o = '0;
    unique case (mid_data_i.op)
      OP_DONE: begin
        res_data_o.status = STATUS_OK;
        res_data_o.len    = mid_data_i.len;
        if (is_signed(mid_data_i.kind)) begin
          res_data_o.value = (masked >> 1) ^ {ValueW{masked[0]}};
        end else begin
          res_data_o.value = masked;
        end
      end
      OP_FAIL: begin
        res_data_o.status = mid_data_i.status;
      end
      default: begin
        res_data_o = '0;
      end
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    if (mid_pop_o) begin
      acc_d = emits ? '0 : acc_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

// ----- src/varint_zigzag_field_decoder.sv -----
// Decodes a serialized byte stream, one byte per clock, into fields: unsigned
// and zigzag-signed varints of 16, 32 and 64 bits (at most 3, 5 and 10 bytes),
// single raw bytes and 8-byte little-endian raw words. The field kind is
// sampled with the first byte of each field; byte_valid_i low ends a field in
// progress with a truncated status. One result comes out per finished or failed
// field; it is registered in the decoder queue and then in the result queue,
// from which it shows on the result ports and can be popped. A new byte is
// accepted every clock while the short queue behind the classifier has room;
// the only stall comes from results that are not popped, which backs up through
// the result queue and the decoder queue to full.
module varint_zigzag_field_decoder
  import vzd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic [2:0]  field_kind_i,
  input  logic        byte_valid_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] value_o,
  output logic [1:0]  status_o,
  output logic [3:0]  byte_length_o
);

  logic    mid_push, mid_full, mid_pop, mid_empty;
  mid_t    mid_in, mid_out;
  logic    res_push, res_full;
  result_t res_in, res_out;

  vzd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (mid_full),
    .data_byte_i  (data_byte_i),
    .field_kind_i (field_kind_i),
    .byte_valid_i (byte_valid_i),
    .mid_push_o   (mid_push),
    .mid_data_o   (mid_in)
  );

  assign full = mid_full;

  vzd_fifo #(
    .Width ($bits(mid_t))
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  vzd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_data_i  (mid_out),
    .mid_pop_o   (mid_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_data_o  (res_in)
  );

  vzd_fifo #(
    .Width ($bits(result_t))
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign value_o       = res_out.value;
  assign status_o      = res_out.status;
  assign byte_length_o = res_out.len;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import vzd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       valid;
  } stream_word_t;

  typedef struct packed {
    logic [63:0] value;
    status_e     status;
    logic [3:0]  len;
  } field_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i = 8'h00;
  logic [2:0]  field_kind_i = 3'd0;
  logic        byte_valid_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] value_o;
  logic [1:0]  status_o;
  logic [3:0]  byte_length_o;

  stream_word_t bytes_to_send[$];
  field_t       fields_due[$];
  stream_word_t word_on_bus;
  int unsigned  words_total = 0;
  int unsigned  words_taken = 0;
  int unsigned  errors = 0;
  logic         stalled;

  // Decoder state as the predictor sees it.
  logic [63:0]  acc_q = '0;
  logic [3:0]   taken_q = '0;
  kind_e        kind_q = KIND_U16;
  logic         busy_q = 1'b0;

  varint_zigzag_field_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .data_byte_i   (data_byte_i),
    .field_kind_i  (field_kind_i),
    .byte_valid_i  (byte_valid_i),
    .empty         (empty),
    .pop           (pop),
    .value_o       (value_o),
    .status_o      (status_o),
    .byte_length_o (byte_length_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int unsigned varint_limit(input kind_e k);
    case (k)
      KIND_U16, KIND_S16: return 3;
      KIND_U32, KIND_S32: return 5;
      default:            return 10;
    endcase
  endfunction

  // Idle percentage per third of the run: sender and receiver trade places, then
  // the last third runs at full rate.
  function automatic int unsigned idle_pct(input bit sender);
    int unsigned third;
    third = (words_total == 0) ? 0 : words_taken * 3 / words_total;
    case (third)
      0:       return sender ? 9 : 79;
      1:       return sender ? 79 : 9;
      default: return 0;
    endcase
  endfunction

  task automatic finish_field(input logic [63:0] v, input status_e s, input logic [3:0] n);
    fields_due.push_back('{v, s, n});
    acc_q   = '0;
    taken_q = '0;
    busy_q  = 1'b0;
  endtask

  task automatic decode_word(input stream_word_t w);
    int unsigned idx;
    int unsigned lim;
    logic [63:0] v;
    if (!w.valid) begin
      if (busy_q) finish_field('0, STATUS_TRUNC, 4'd0);
    end else begin
      if (!busy_q) begin
        kind_q  = w.kind;
        acc_q   = '0;
        taken_q = '0;
        busy_q  = 1'b1;
      end
      idx = taken_q;
      if (kind_q == KIND_RAW1) begin
        finish_field({56'd0, w.data}, STATUS_OK, 4'd1);
      end else if (kind_q == KIND_RAW8) begin
        if (idx > 7) idx = 7;
        acc_q |= {56'd0, w.data} << (8 * idx);
        if (idx == 7) finish_field(acc_q, STATUS_OK, 4'd8);
        else taken_q = 4'(idx + 1);
      end else begin
        lim = varint_limit(kind_q);
        if (idx >= lim) idx = lim - 1;
        acc_q |= {57'd0, w.data[6:0]} << (7 * idx);
        if (w.data[7]) begin
          if (idx + 1 >= lim) finish_field('0, STATUS_TOO_LONG, 4'd0);
          else taken_q = 4'(idx + 1);
        end else begin
          v = acc_q;
          if (lim == 3) v = v & 64'hFFFF;
          else if (lim == 5) v = v & 64'hFFFF_FFFF;
          if (kind_q inside {KIND_S16, KIND_S32, KIND_S64}) v = (v >> 1) ^ {64{v[0]}};
          finish_field(v, STATUS_OK, 4'(idx + 1));
        end
      end
    end
  endtask

  function automatic void add_word(input logic [7:0] d, input logic [2:0] k, input logic v);
    bytes_to_send.push_back('{d, kind_e'(k), v});
  endfunction

  initial begin
    int unsigned counted;
    int unsigned n;
    int unsigned m;
    kind_e       k;
    logic [7:0]  b;
    bit          bad;
    bit          cut;
    // Directed: extremes, every kind, too long, truncated, idle end of buffer.
    add_word(8'h00, KIND_U16, 1'b1);
    add_word(8'h01, KIND_S16, 1'b1);
    add_word(8'hFE, KIND_S16, 1'b1);
    add_word(8'hFF, KIND_RAW8, 1'b1);
    add_word(8'h7F, KIND_U32, 1'b1);
    add_word(8'hFF, KIND_U16, 1'b1);
    add_word(8'hFF, KIND_U16, 1'b1);
    add_word(8'hFF, KIND_U16, 1'b1);
    add_word(8'hFF, KIND_U32, 1'b1);
    add_word(8'hFF, KIND_U16, 1'b1);
    add_word(8'hFF, KIND_S64, 1'b1);
    add_word(8'hFF, KIND_RAW1, 1'b1);
    add_word(8'h0F, KIND_S32, 1'b1);
    add_word(8'hFF, KIND_RAW1, 1'b1);
    add_word(8'h01, KIND_RAW8, 1'b1);
    add_word(8'h23, KIND_U16, 1'b1);
    add_word(8'h00, KIND_U16, 1'b1);
    add_word(8'hFF, KIND_U16, 1'b1);
    add_word(8'h89, KIND_U16, 1'b1);
    add_word(8'hAB, KIND_U16, 1'b1);
    add_word(8'hCD, KIND_U16, 1'b1);
    add_word(8'hEF, KIND_U16, 1'b1);
    add_word(8'h55, KIND_RAW8, 1'b0);
    add_word(8'h80, KIND_U64, 1'b1);
    add_word(8'h00, KIND_U64, 1'b0);
    add_word(8'h03, KIND_S32, 1'b1);
    add_word(8'h7E, KIND_S64, 1'b1);
    counted = bytes_to_send.size();
    // Random: mostly well-formed fields with random content, some too long,
    // some cut short, and a little end-of-buffer noise between fields.
    while (counted < 1100) begin
      if ($urandom_range(99) < 5) begin
        add_word(8'($urandom_range(255)), 3'($urandom_range(7)), 1'b0);
      end else begin
        k = kind_e'($urandom_range(7));
        bad = 1'b0;
        if (k == KIND_RAW1) n = 1;
        else if (k == KIND_RAW8) n = 8;
        else begin
          n = ($urandom_range(3) == 0) ? varint_limit(k) : $urandom_range(1, varint_limit(k));
          bad = ($urandom_range(99) < 10);
          if (bad) n = varint_limit(k);
        end
        cut = (n > 1) && ($urandom_range(99) < 8);
        m = cut ? $urandom_range(1, n - 1) : n;
        for (int unsigned i = 0; i < m; i++) begin
          b = 8'($urandom_range(255));
          if (k != KIND_RAW1 && k != KIND_RAW8) b[7] = (i < n - 1) || bad;
          add_word(b, (i == 0) ? k : 3'($urandom_range(7)), 1'b1);
        end
        if (cut) add_word(8'($urandom_range(255)), 3'($urandom_range(7)), 1'b0);
        counted += m + (cut ? 1 : 0);
      end
    end
    words_total = bytes_to_send.size();
  end

  // Driver: a word is held while the block is full and replaced once it is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      stalled = push && full;
      if (push && !full) begin
        decode_word(word_on_bus);
        words_taken++;
      end
      if (!stalled) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          word_on_bus = bytes_to_send.pop_front();
          push         <= 1'b1;
          data_byte_i  <= word_on_bus.data;
          field_kind_i <= word_on_bus.kind;
          byte_valid_i <= word_on_bus.valid;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  task automatic check_field();
    field_t exp;
    if (fields_due.size() == 0) begin
      $error("unexpected result: value %h status %0d byte_length %0d",
             value_o, status_o, byte_length_o);
      errors++;
    end else begin
      exp = fields_due.pop_front();
      if (value_o !== exp.value) begin
        $error("value: expected %h, got %h", exp.value, value_o);
        errors++;
      end
      if (status_o !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, status_o);
        errors++;
      end
      if (byte_length_o !== exp.len) begin
        $error("byte_length: expected %0d, got %0d", exp.len, byte_length_o);
        errors++;
      end
    end
  endtask

  // Monitor: checks each popped result and draws pop for the next cycle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_field();
      pop <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  initial begin
    @(posedge rst_ni);
    do @(posedge clk_i);
    while (bytes_to_send.size() != 0 || push || fields_due.size() != 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && fields_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- varint_zigzag_field_decoder.f -----
src/vzd_pkg.sv
src/vzd_fifo.sv
src/vzd_front.sv
src/vzd_back.sv
src/varint_zigzag_field_decoder.sv
test/tb_top.sv
